FILE: hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the script character tokenizer
// Item layouts, lexer modes, character classes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  // Longest token is MAX_TOKEN-1 stored characters
  localparam int unsigned MAX_TOKEN = 1024;
  localparam int unsigned LEN_W     = $clog2(MAX_TOKEN);

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // Characters with a role of their own
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_QUOTE   = 8'd34;
  localparam logic [7:0] CH_SLASH   = 8'd47;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_LBRACE  = 8'd123;
  localparam logic [7:0] CH_RBRACE  = 8'd125;
  localparam logic [7:0] CH_LPAREN  = 8'd40;
  localparam logic [7:0] CH_RPAREN  = 8'd41;
  localparam logic [7:0] CH_LBRACK  = 8'd91;
  localparam logic [7:0] CH_RBRACK  = 8'd93;
  localparam logic [7:0] CH_COMMA   = 8'd44;
  localparam logic [7:0] CH_COLON   = 8'd58;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_HIGH    = 8'd128;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [3:0] {
    MD_IDLE      = 4'd0,
    MD_WORD      = 4'd1,
    MD_SPECIAL   = 4'd2,
    MD_QUOTE     = 4'd3,
    MD_ENDQUOTE  = 4'd4,
    MD_SLASH     = 4'd5,
    MD_LINE      = 4'd6,
    MD_BLOCK     = 4'd7,
    MD_BLOCKSTAR = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    CL_NEWLINE,
    CL_QUOTE,
    CL_SLASH,
    CL_STAR,
    CL_SPECIAL,
    CL_WORD,
    CL_SPACE
  } class_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_out;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } res_t;

  // One queue entry: all results of one input item
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     res;
  } entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Sort a byte into its lexical class
  function automatic class_e classify(logic [7:0] c, logic special);
    class_e cl;
    case (c) inside
      CH_NEWLINE: cl = CL_NEWLINE;
      CH_QUOTE:   cl = CL_QUOTE;
      CH_SLASH:   cl = CL_SLASH;
      CH_STAR:    cl = CL_STAR;
      CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
      CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON:
        cl = special ? CL_SPECIAL : CL_WORD;
      default:
        cl = (c > CH_SPACE && c < CH_HIGH) ? CL_WORD : CL_SPACE;
    endcase
    return cl;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/script_char_tokenizer.sv
// Results of an item are registered in the result queue before the back end offers them.
// Throughput: one input item per cycle while the 4-entry result queue has room;
// the output gives one result per cycle while out_ready_i is high; an entry leaves with its last result.
// Items that give no result take no queue space.
// Reset (rst_ni low, asynchronous): lexer idle, token length 0, special mode off,
// queue empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
// script_char_tokenizer: byte stream lexer top level
// Front end lexes bytes into result entries, a queue decouples it from the
// back end that streams token characters and end markers out.
// ----------------------------------------------------------------------------
`default_nettype none

module script_char_tokenizer import sct_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i
);

  q_stat_t q_stat;
  logic    push, pop;
  entry_t  push_data, head;

  sct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .stat_o      (q_stat),
    .head_o      (head)
  );

  sct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hdl/sct_front.sv
// ----------------------------------------------------------------------------
// sct_front: lexer front end
// Accepts items, runs the lexer state machine and packs every result of an
// item into one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_front import sct_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire in_t     in_data_i,
  input  wire logic    cfg_we_i,
  input  wire logic    cfg_wdata_i,
  input  wire q_stat_t q_stat_i,
  output logic         push_o,
  output entry_t       push_data_o
);

  typedef struct packed {
    mode_e            mode;
    logic [LEN_W-1:0] len;
    entry_t           ent;
  } work_t;

  mode_e            mode_q, mode_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             special_q;
  logic             accept;
  class_e           cl;
  work_t            w;

  // Append one result to the entry
  function automatic work_t put(work_t wi, logic k, logic [7:0] ch);
    work_t wo;
    wo = wi;
    case (wi.ent.cnt)
      2'd0: wo.ent.res[0] = '{kind: k, ch: ch};
      2'd1: wo.ent.res[1] = '{kind: k, ch: ch};
      2'd2: wo.ent.res[2] = '{kind: k, ch: ch};
      default: ;
    endcase
    if (wi.ent.cnt != 2'd3) begin
      wo.ent.cnt = wi.ent.cnt + 2'd1;
    end
    return wo;
  endfunction

  // Store a token character unless the token is full
  function automatic work_t add_char(work_t wi, logic [7:0] c);
    work_t wo;
    wo = wi;
    if (wi.len < LEN_W'(MAX_TOKEN - 1)) begin
      wo.len = wi.len + LEN_W'(1);
      wo     = put(wo, KIND_CHAR, c);
    end
    return wo;
  endfunction

  // Close the current token
  function automatic work_t end_token(work_t wi);
    work_t wo;
    wo      = put(wi, KIND_END, 8'd0);
    wo.len  = '0;
    wo.mode = MD_IDLE;
    return wo;
  endfunction

  // Handle a byte from the idle state
  function automatic work_t idle_byte(work_t wi, logic [7:0] c, class_e k);
    work_t wo;
    wo = wi;
    case (k)
      CL_WORD, CL_STAR: begin
        wo.mode = MD_WORD;
        wo      = add_char(wo, c);
      end
      CL_SPECIAL: begin
        wo.mode = MD_SPECIAL;
        wo      = add_char(wo, c);
      end
      CL_QUOTE: wo.mode = MD_QUOTE;
      CL_SLASH: wo.mode = MD_SLASH;
      default: ;
    endcase
    return wo;
  endfunction

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and results of the offered item
  always_comb begin
    cl = classify(in_data_i.char_in, special_q);
    w  = '{mode: mode_q, len: len_q, ent: '0};
    if (in_data_i.stream_end) begin
      if (len_q != '0) begin
        w = put(w, KIND_END, 8'd0);
      end
      w.len  = '0;
      w.mode = MD_IDLE;
    end else begin
      unique case (mode_q)
        MD_WORD: begin
          if (cl == CL_WORD || cl == CL_SLASH || cl == CL_STAR) begin
            w = add_char(w, in_data_i.char_in);
          end else begin
            w = idle_byte(end_token(w), in_data_i.char_in, cl);
          end
        end
        MD_SPECIAL, MD_ENDQUOTE: begin
          w = idle_byte(end_token(w), in_data_i.char_in, cl);
        end
        MD_QUOTE: begin
          if (cl == CL_QUOTE) begin
            w.mode = MD_ENDQUOTE;
          end else if (cl != CL_NEWLINE) begin
            w = add_char(w, in_data_i.char_in);
          end
        end
        MD_SLASH: begin
          if (cl == CL_WORD) begin
            w      = add_char(w, CH_SLASH);
            w      = add_char(w, in_data_i.char_in);
            w.mode = MD_WORD;
          end else if (cl == CL_SLASH) begin
            w.mode = MD_LINE;
          end else if (cl == CL_STAR) begin
            w.mode = MD_BLOCK;
          end else begin
            w = add_char(w, CH_SLASH);
            w = idle_byte(end_token(w), in_data_i.char_in, cl);
          end
        end
        MD_LINE: begin
          if (cl == CL_NEWLINE) begin
            w.mode = MD_IDLE;
          end
        end
        MD_BLOCK: begin
          if (cl == CL_STAR) begin
            w.mode = MD_BLOCKSTAR;
          end
        end
        MD_BLOCKSTAR: begin
          if (cl == CL_SLASH) begin
            w.mode = MD_IDLE;
          end else if (cl != CL_STAR) begin
            w.mode = MD_BLOCK;
          end
        end
        default: begin
          w = idle_byte(w, in_data_i.char_in, cl);
        end
      endcase
    end
    mode_d = accept ? w.mode : mode_q;
    len_d  = accept ? w.len  : len_q;
  end

  // Push only items that give results
  assign push_o      = accept && (w.ent.cnt != 2'd0);
  assign push_data_o = w.ent;

  // Lexer state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MD_IDLE;
      len_q     <= '0;
      special_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      if (cfg_we_i) begin
        special_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sct_queue.sv
// ----------------------------------------------------------------------------
// sct_queue: result entry queue
// Short FIFO that decouples the lexer front from the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_queue import sct_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_data_i,
  input  wire logic   pop_i,
  output q_stat_t     stat_o,
  output entry_t      head_o
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Write storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sct_back.sv
// ----------------------------------------------------------------------------
// sct_back: result back end
// Walks the results of the head queue entry out one item per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_back import sct_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_stat_t q_stat_i,
  input  wire entry_t  head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_t         out_data_o
);

  logic [1:0] idx_q, idx_d;
  res_t       cur;
  logic       is_last;
  logic       fire;

  // Select the current result of the head entry
  assign cur     = head_i.res[idx_q];
  assign is_last = (idx_q == head_i.cnt - 2'd1);
  assign fire    = out_valid_o && out_ready_i;

  assign out_valid_o         = !q_stat_i.empty;
  assign out_data_o.kind     = cur.kind;
  assign out_data_o.char_out = cur.ch;
  assign out_data_o.last     = is_last;
  assign pop_o               = fire && is_last;

  // Advance through the entry, restart on pop
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sct_checker.sv
// ----------------------------------------------------------------------------
// sct_checker: port level checks for the tokenizer
// Watches the output channel for stall behaviour and impossible results.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_checker import sct_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // End markers carry no character
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_END |-> out_data_o.char_out == 8'd0)
    else $error("end marker with nonzero character");

  // Newlines are never token characters
  a_no_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_CHAR |-> out_data_o.char_out != CH_NEWLINE)
    else $error("newline emitted as token character");

  // Quotes delimit strings and are never stored
  a_no_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_CHAR |-> out_data_o.char_out != CH_QUOTE)
    else $error("quote emitted as token character");

endmodule

bind script_char_tokenizer sct_checker u_sct_checker (.*);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the script character tokenizer
// Feeds directed and randomly built script text, byte by byte, with random
// gaps on the input and stalls on the output. Every accepted item is run
// through a behavioural lexer in the bench. Each result from the block is
// checked against the oldest predicted one.
// ----------------------------------------------------------------------------

module tb;
  import sct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Block ports
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  // Bench lexer state
  mode_e       lex_mode = MD_IDLE;
  int unsigned tok_len  = 0;
  logic        spec_on  = 1'b0;

  // Results of the item being predicted, then all results still owed
  out_t item_results[$];
  out_t token_stream_q[$];

  // Idling, in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Counters
  int unsigned cycle_cnt    = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned token_ends   = 0;
  int unsigned error_cnt    = 0;

  script_char_tokenizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Behavioural lexer
  // ------------------------------------------------------------------

  function automatic class_e byte_class(logic [7:0] c);
    case (c)
      CH_NEWLINE: return CL_NEWLINE;
      CH_QUOTE:   return CL_QUOTE;
      CH_SLASH:   return CL_SLASH;
      CH_STAR:    return CL_STAR;
      CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
      CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON:
        return spec_on ? CL_SPECIAL : CL_WORD;
      default:
        return (c > CH_SPACE && c < CH_HIGH) ? CL_WORD : CL_SPACE;
    endcase
  endfunction

  function automatic void push_result(logic k, logic [7:0] ch);
    out_t r;
    r.kind     = k;
    r.char_out = ch;
    r.last     = 1'b0;
    if (item_results.size() < 3) item_results.push_back(r);
  endfunction

  // Store one token character unless the token is already full
  function automatic void store_char(logic [7:0] c);
    if (tok_len < MAX_TOKEN - 1) begin
      tok_len++;
      push_result(KIND_CHAR, c);
    end
  endfunction

  function automatic void close_token();
    push_result(KIND_END, 8'd0);
    tok_len  = 0;
    lex_mode = MD_IDLE;
  endfunction

  // Start of a token from the idle state
  function automatic void lex_from_idle(logic [7:0] c);
    case (byte_class(c))
      CL_WORD, CL_STAR: begin
        lex_mode = MD_WORD;
        store_char(c);
      end
      CL_SPECIAL: begin
        lex_mode = MD_SPECIAL;
        store_char(c);
      end
      CL_QUOTE: lex_mode = MD_QUOTE;
      CL_SLASH: lex_mode = MD_SLASH;
      default: ;
    endcase
  endfunction

  // Advance the lexer by one item and queue the tokens it produces
  function automatic void predict_tokens(in_t it);
    class_e     cl;
    logic [7:0] c;
    c = it.char_in;
    item_results.delete();
    if (it.stream_end) begin
      if (tok_len != 0) push_result(KIND_END, 8'd0);
      tok_len  = 0;
      lex_mode = MD_IDLE;
    end else begin
      cl = byte_class(c);
      case (lex_mode)
        MD_WORD: begin
          if (cl == CL_WORD || cl == CL_SLASH || cl == CL_STAR) begin
            store_char(c);
          end else begin
            close_token();
            lex_from_idle(c);
          end
        end
        MD_SPECIAL, MD_ENDQUOTE: begin
          close_token();
          lex_from_idle(c);
        end
        MD_QUOTE: begin
          if (cl == CL_QUOTE) lex_mode = MD_ENDQUOTE;
          else if (cl != CL_NEWLINE) store_char(c);
        end
        MD_SLASH: begin
          if (cl == CL_WORD) begin
            store_char(CH_SLASH);
            store_char(c);
            lex_mode = MD_WORD;
          end else if (cl == CL_SLASH) begin
            lex_mode = MD_LINE;
          end else if (cl == CL_STAR) begin
            lex_mode = MD_BLOCK;
          end else begin
            store_char(CH_SLASH);
            close_token();
            lex_from_idle(c);
          end
        end
        MD_LINE: if (c == CH_NEWLINE) lex_mode = MD_IDLE;
        MD_BLOCK: if (c == CH_STAR) lex_mode = MD_BLOCKSTAR;
        MD_BLOCKSTAR: begin
          if (c == CH_SLASH) lex_mode = MD_IDLE;
          else if (c != CH_STAR) lex_mode = MD_BLOCK;
        end
        default: begin
          lex_mode = MD_IDLE;
          lex_from_idle(c);
        end
      endcase
    end
    if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
    foreach (item_results[i]) token_stream_q.push_back(item_results[i]);
  endfunction

  // ------------------------------------------------------------------
  // Output side: stall at random and check every result
  // ------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (token_stream_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result kind=%0d char=%02h last=%0d", $realtime,
                   out_data_o.kind, out_data_o.char_out, out_data_o.last);
      end else begin
        exp_r = token_stream_q.pop_front();
        if (exp_r.kind == KIND_END) token_ends++;
        if (out_data_o.kind !== exp_r.kind || out_data_o.char_out !== exp_r.char_out ||
            out_data_o.last !== exp_r.last) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("%0t: mismatch exp kind=%0d char=%02h last=%0d, got kind=%0d char=%02h last=%0d",
                     $realtime, exp_r.kind, exp_r.char_out, exp_r.last,
                     out_data_o.kind, out_data_o.char_out, out_data_o.last);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung block
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               token_stream_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------

  // Offer one item, after a random gap, and hold it until accepted
  task automatic send_item(input logic [7:0] ch, input logic fin);
    in_t it;
    it.char_in    = ch;
    it.stream_end = fin;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    predict_tokens(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (token_stream_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the mode register once the block has gone quiet
  task automatic set_special_mode(input logic v);
    stop_input();
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    spec_on  = v;
    cfg_we_i <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Random text pieces
  // ------------------------------------------------------------------

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 127));
    if (c == CH_QUOTE) c = "a";
    return c;
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(7))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LPAREN;
      3: return CH_RPAREN;
      4: return CH_LBRACK;
      5: return CH_RBRACK;
      6: return CH_COMMA;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_NEWLINE;
      2: return 8'($urandom_range(0, 32));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Brackets and friends are word characters at the reset mode
  task automatic test_reset_mode();
    send_text("a{b}(c),d:e[f] ");
    send_text("*y ");
    set_special_mode(1'b0);
  endtask

  task automatic test_specials();
    set_special_mode(1'b1);
    send_text("{x}(,)[:] ab{cd ");
  endtask

  // Newline dropped inside a string, empty strings, string hard against a word
  task automatic test_quoted_strings();
    send_text("\"ab\ncd\" \"\"x \"q\"{ w\"s\" ");
    send_text("\"\"");
    send_end();
  endtask

  // Slash before word, lone slashes, comments, pending slash at stream end
  task automatic test_slash_cases();
    send_text("/w / /\"a\" /{ /\n a/b*c //note\nk /*x**/m ");
    send_text("/");
    send_end();
  endtask

  // Stream end with and without a token, boundary bytes
  task automatic test_stream_end();
    send_text("tok");
    send_end();
    send_end();
    send_item(8'd0, 1'b0);
    send_item(8'd33, 1'b0);
    send_item(8'd127, 1'b0);
    send_item(8'd128, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd32, 1'b0);
    send_item(8'd255, 1'b1);
  endtask

  // Characters past the longest token are dropped
  task automatic test_overlong_token();
    repeat (MAX_TOKEN + 6) send_item("z", 1'b0);
    send_item(CH_SPACE, 1'b0);
  endtask

  // Mostly well-formed script pieces with random content, plus some noise
  task automatic test_random_text(input int unsigned n_items);
    int unsigned start_cnt;
    int unsigned len;
    start_cnt = items_sent;
    while (items_sent - start_cnt < n_items) begin
      case ($urandom_range(11))
        0, 1, 2: begin
          len = $urandom_range(1, 8);
          repeat (len) send_item(word_char(), 1'b0);
          send_item(blank_char(), 1'b0);
        end
        3: begin
          send_item(CH_QUOTE, 1'b0);
          len = $urandom_range(0, 6);
          repeat (len) begin
            if ($urandom_range(5) == 0) send_item(CH_NEWLINE, 1'b0);
            else send_item(word_char(), 1'b0);
          end
          if ($urandom_range(9) != 0) send_item(CH_QUOTE, 1'b0);
        end
        4: send_item(special_char(), 1'b0);
        5: begin
          send_text("//");
          len = $urandom_range(0, 5);
          repeat (len) send_item(word_char(), 1'b0);
          send_item(CH_NEWLINE, 1'b0);
        end
        6: begin
          send_text("/*");
          len = $urandom_range(0, 5);
          repeat (len) begin
            if ($urandom_range(3) == 0) send_item(CH_STAR, 1'b0);
            else send_item(8'($urandom_range(255)), 1'b0);
          end
          send_text("*/");
        end
        7: begin
          send_item(CH_SLASH, 1'b0);
          if ($urandom_range(1)) send_item(blank_char(), 1'b0);
          else send_item(special_char(), 1'b0);
        end
        8, 9: send_item(blank_char(), 1'b0);
        10: send_end();
        default: begin
          len = $urandom_range(1, 4);
          repeat (len) send_item(8'($urandom_range(255)), 1'b0);
        end
      endcase
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 75;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_mode();
    test_specials();
    test_quoted_strings();
    test_slash_cases();
    test_stream_end();
    test_overlong_token();

    set_special_mode(1'b0);
    test_random_text(100);

    send_idle_pct = 75;
    recv_idle_pct = 13;
    set_special_mode(1'b1);
    test_random_text(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_special_mode(1'b0);
    test_random_text(100);

    stop_input();
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes of script text over both special modes and three idling mixes",
             items_sent);
    $display("Checked %0d results closing %0d tokens, %0d errors", results_seen,
             token_ends, error_cnt);
    if (error_cnt == 0 && token_stream_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d results never arrived", token_stream_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
